// File: rtl/core/adaptive_morse_key_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ADAPTIVE_MORSE_KEY_DECODER_MACROS_SVH
`define ADAPTIVE_MORSE_KEY_DECODER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AMKD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define AMKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/amkd_pkg.sv
package amkd_pkg;

  localparam int MAX_SYMBOLS   = 8;
  localparam int TABLE_ENTRIES = 36;
  localparam int ROM_SIZE      = 36;

  localparam int CNT_W  = 20;
  localparam int DASH_W = 16;
  localparam int PAT_W  = 8;
  localparam int LEN_W  = 4;
  localparam int CODE_W = 7;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = 20'hFFFFF;
  localparam logic [DASH_W-1:0] DASH_MAX   = 16'hFFFF;
  localparam logic [DASH_W-1:0] DASH_MIN   = 16'd1;
  localparam logic [DASH_W-1:0] DASH_RESET = 16'd200;
  localparam logic [CNT_W-1:0]  SHORT_MARK = 20'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [PAT_W-1:0]  bits;
    logic [CODE_W-1:0] code;
  } morse_entry_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } lookup_t;

  // Symbol k of a pattern sits in bit k, a dash is a one.
  localparam morse_entry_t MORSE_ROM [ROM_SIZE] = '{
    '{4'd2, 8'd2,  7'h41}, '{4'd4, 8'd1,  7'h42}, '{4'd4, 8'd5,  7'h43},
    '{4'd3, 8'd1,  7'h44}, '{4'd1, 8'd0,  7'h45}, '{4'd4, 8'd4,  7'h46},
    '{4'd3, 8'd3,  7'h47}, '{4'd4, 8'd0,  7'h48}, '{4'd2, 8'd0,  7'h49},
    '{4'd4, 8'd14, 7'h4A}, '{4'd3, 8'd5,  7'h4B}, '{4'd4, 8'd2,  7'h4C},
    '{4'd2, 8'd3,  7'h4D}, '{4'd2, 8'd1,  7'h4E}, '{4'd3, 8'd7,  7'h4F},
    '{4'd4, 8'd6,  7'h50}, '{4'd4, 8'd11, 7'h51}, '{4'd3, 8'd2,  7'h52},
    '{4'd3, 8'd0,  7'h53}, '{4'd1, 8'd1,  7'h54}, '{4'd3, 8'd4,  7'h55},
    '{4'd4, 8'd8,  7'h56}, '{4'd3, 8'd6,  7'h57}, '{4'd4, 8'd9,  7'h58},
    '{4'd4, 8'd13, 7'h59}, '{4'd4, 8'd3,  7'h5A},
    '{4'd5, 8'd31, 7'h30}, '{4'd5, 8'd30, 7'h31}, '{4'd5, 8'd28, 7'h32},
    '{4'd5, 8'd24, 7'h33}, '{4'd5, 8'd16, 7'h34}, '{4'd5, 8'd0,  7'h35},
    '{4'd5, 8'd1,  7'h36}, '{4'd5, 8'd3,  7'h37}, '{4'd5, 8'd7,  7'h38},
    '{4'd5, 8'd15, 7'h39}
  };

  function automatic lookup_t morse_lookup(input logic [LEN_W-1:0] len,
                                           input logic [PAT_W-1:0] bits);
    lookup_t res;
    res = '0;
    for (int i = ROM_SIZE - 1; i >= 0; i--) begin
      if (i < TABLE_ENTRIES && MORSE_ROM[i].len == len && MORSE_ROM[i].bits == bits) begin
        res.hit  = 1'b1;
        res.code = MORSE_ROM[i].code;
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/adaptive_morse_key_decoder.sv
// Adaptive Morse key decoder: one key sample per tick in, one result per tick out, while out_stall is low.
// A transferred sample is held in the input register, and its result is offered from the result register.
// Throughput: one transfer per cycle while out_stall is low; the decode and state update sit
// between the input register and the result register, so the state loop sets the rate.
// Reset (synchronous, rst_n low): counters and pattern clear, dash length returns to 200.
`include "adaptive_morse_key_decoder_macros.svh"

module adaptive_morse_key_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_key_down,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_tone_on,
  output logic                        out_char_valid,
  output logic [amkd_pkg::CODE_W-1:0] out_char_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [amkd_pkg::DASH_W-1:0] cfg_initial_dash_ticks
);

  localparam int W22 = 22;
  localparam int W26 = 26;

  logic                        s1_vld_r;
  logic                        s1_key_r;
  logic                        out_vld_r;
  logic                        out_tone_r;
  logic                        out_cv_r;
  logic [amkd_pkg::CODE_W-1:0] out_code_r;

  logic                        key_before_r;
  logic [amkd_pkg::CNT_W-1:0]  mark_r, mark_nxt;
  logic [amkd_pkg::CNT_W-1:0]  gap_r, gap_nxt;
  logic [amkd_pkg::DASH_W-1:0] dash_r, dash_nxt;
  logic [amkd_pkg::PAT_W-1:0]  pat_r, pat_nxt;
  logic [amkd_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic                        ovf_r, ovf_nxt;

  logic                        adv, fire, accept;
  logic                        press, release_k;
  logic [amkd_pkg::CNT_W-1:0]  gap_inc, mark_t;
  logic [W26-1:0]              gap40, dash39, t57, dash40;
  logic [W22-1:0]              t3, dash_w;
  logic [amkd_pkg::CNT_W-1:0]  dash10, dash_c;
  logic                        end_pat, is_dash, long_mark, char_vld;
  amkd_pkg::lookup_t           lk;
  logic [amkd_pkg::DASH_W-1:0] cfg_dash;

  assign adv      = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_dash = (cfg_initial_dash_ticks == '0) ? amkd_pkg::DASH_MIN
                                                   : cfg_initial_dash_ticks;

  always_comb begin
    press     = s1_key_r && !key_before_r;
    release_k = !s1_key_r && key_before_r;
    gap_inc   = (gap_r == amkd_pkg::COUNT_MAX) ? gap_r : gap_r + 20'd1;
    mark_t    = press ? '0 :
                ((mark_r == amkd_pkg::COUNT_MAX) ? mark_r : mark_r + 20'd1);

    dash_w = W22'(dash_r);
    dash_c = amkd_pkg::CNT_W'(dash_r);
    gap40  = (W26'(gap_inc) << 5) + (W26'(gap_inc) << 3);
    dash39 = (W26'(dash_r) << 5) + (W26'(dash_r) << 2) + (W26'(dash_r) << 1) + W26'(dash_r);
    dash10 = (dash_c << 3) + (dash_c << 1);
    t3     = W22'(mark_t) + (W22'(mark_t) << 1);
    t57    = (W26'(mark_t) << 5) + (W26'(mark_t) << 4) + (W26'(mark_t) << 3) + W26'(mark_t);
    dash40 = (W26'(dash_r) << 5) + (W26'(dash_r) << 3);

    end_pat = (cnt_r != '0) &&
              ((press && (gap40 > dash39)) ||
               (!press && !release_k && (gap_inc > dash10)));
    lk       = amkd_pkg::morse_lookup(cnt_r, pat_r);
    char_vld = end_pat && !ovf_r && lk.hit;

    long_mark = mark_t > amkd_pkg::SHORT_MARK;
    if (t3 <= dash_w) begin
      is_dash = 1'b0;
    end else if (mark_t > dash_c) begin
      is_dash = 1'b1;
    end else begin
      is_dash = t57 > dash40;
    end

    mark_nxt = mark_t;
    gap_nxt  = release_k ? '0 : gap_inc;
    dash_nxt = dash_r;
    pat_nxt  = pat_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;

    if (end_pat) begin
      pat_nxt = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end

    if (release_k && long_mark) begin
      if (is_dash) begin
        if (mark_t > dash_c && dash_r != amkd_pkg::DASH_MAX) begin
          dash_nxt = dash_r + 16'd1;
        end else if (mark_t < dash_c && dash_r != amkd_pkg::DASH_MIN) begin
          dash_nxt = dash_r - 16'd1;
        end
      end else begin
        if (t3 > dash_w && dash_r != amkd_pkg::DASH_MAX) begin
          dash_nxt = dash_r + 16'd1;
        end else if (t3 < dash_w && dash_r != amkd_pkg::DASH_MIN) begin
          dash_nxt = dash_r - 16'd1;
        end
      end
      if (cnt_r < amkd_pkg::LEN_W'(amkd_pkg::MAX_SYMBOLS)) begin
        pat_nxt = pat_r | (amkd_pkg::PAT_W'(is_dash) << cnt_r[amkd_pkg::LEN_W-2:0]);
        cnt_nxt = cnt_r + 4'd1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      key_before_r <= 1'b0;
      mark_r       <= '0;
      gap_r        <= '0;
      dash_r       <= amkd_pkg::DASH_RESET;
      pat_r        <= '0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (fire) begin
        s1_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (fire) begin
        key_before_r <= s1_key_r;
        mark_r       <= mark_nxt;
        gap_r        <= gap_nxt;
        pat_r        <= pat_nxt;
        cnt_r        <= cnt_nxt;
        ovf_r        <= ovf_nxt;
      end
      if (cfg_valid) begin
        dash_r <= cfg_dash;
      end else if (fire) begin
        dash_r <= dash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r <= in_key_down;
    end
    if (fire) begin
      out_tone_r <= s1_key_r;
      out_cv_r   <= char_vld;
      out_code_r <= char_vld ? lk.code : '0;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_tone_on    = out_tone_r;
  assign out_char_valid = out_cv_r;
  assign out_char_code  = out_code_r;

  `AMKD_ASSERT_SAME(a_dash_nonzero, 1'b1, dash_r != '0, "dash length reached zero")
  `AMKD_ASSERT_SAME(a_count_bound, 1'b1,
    cnt_r <= amkd_pkg::LEN_W'(amkd_pkg::MAX_SYMBOLS), "pattern count out of range")
  `AMKD_ASSERT_SAME(a_ovf_full, ovf_r,
    cnt_r == amkd_pkg::LEN_W'(amkd_pkg::MAX_SYMBOLS), "overflow set on a partial pattern")
  `AMKD_ASSERT_NEXT(a_code_zero, fire && !char_vld,
    out_char_code == '0, "character code not cleared without a character")

endmodule
